// ===== hw/rtl/gregorian_date_counter_unit_macros.svh =====
// Assertion macros for the date counter unit.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef GREGORIAN_DATE_COUNTER_UNIT_MACROS_SVH
`define GREGORIAN_DATE_COUNTER_UNIT_MACROS_SVH

// Condition holds at every edge out of reset.
`define GDC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("date counter invariant violated");

// Consequent holds at the edge after the antecedent.
`define GDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("date counter sequence violated");

`endif

// ===== hw/rtl/gdc_pkg.sv =====
// Shared types, constants and calendar functions for the date counter.
// No dependencies; used by gdc_step and gregorian_date_counter_unit.
package gdc_pkg;

    typedef logic [4:0]  t_day;
    typedef logic [3:0]  t_month;
    typedef logic [13:0] t_year;
    typedef logic [8:0]  t_days_left;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_DAY   = 2'd1,
        ACT_MONTH = 2'd2,
        ACT_CMP   = 2'd3
    } t_action;

    typedef struct packed {
        t_action action;
        t_day    load_day;
        t_month  load_month;
        t_year   load_year;
    } t_in_word;

    typedef struct packed {
        t_day       cur_day;
        t_month     cur_month;
        t_year      cur_year;
        t_days_left days_left;
        logic       leap_flag;
        logic       is_later;
    } t_out_word;

    // stored date plus the leap bit of its year
    typedef struct packed {
        t_day   day;
        t_month month;
        t_year  year;
        logic   leap;
    } t_date;

    localparam t_year  YEAR_MAX    = 14'd9999;
    localparam t_year  YEAR_RESET  = 14'd2000;
    localparam t_month MONTH_JAN   = 4'd1;
    localparam t_month MONTH_FEB   = 4'd2;
    localparam t_month MONTH_APR   = 4'd4;
    localparam t_month MONTH_JUN   = 4'd6;
    localparam t_month MONTH_SEP   = 4'd9;
    localparam t_month MONTH_NOV   = 4'd11;
    localparam t_month MONTH_DEC   = 4'd12;
    localparam t_day   DAY_FIRST   = 5'd1;
    localparam t_day   LEN_SHORT   = 5'd30;
    localparam t_day   LEN_LONG    = 5'd31;
    localparam t_day   LEN_FEB     = 5'd28;

    // 25 * 7209 == 1 mod 2^14; y is a multiple of 25 iff y*inv mod 2^14 <= 16383/25
    localparam t_year  INV25       = 14'd7209;
    localparam t_year  DIV25_LIMIT = 14'd655;

    // leap: div by 4 and (not by 25, or by 16)  ==  4 but not 100, or 400
    function automatic logic f_leap(input t_year y);
        t_year prod;
        logic  div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:2] == 2'b00));
    endfunction

    function automatic t_day f_month_len(input t_month m, input logic leap);
        t_day len;
        case (m)
            MONTH_FEB: len = LEN_FEB + {4'd0, leap};
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

    // days from the first of month m to the end of the year, inclusive
    function automatic t_days_left f_days_from(input t_month m, input logic leap);
        t_days_left base;
        case (m)
            4'd1:    base = 9'd365;
            4'd2:    base = 9'd334;
            4'd3:    base = 9'd306;
            4'd4:    base = 9'd275;
            4'd5:    base = 9'd245;
            4'd6:    base = 9'd214;
            4'd7:    base = 9'd184;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd122;
            4'd10:   base = 9'd92;
            4'd11:   base = 9'd61;
            default: base = 9'd31;
        endcase
        if (leap && (m <= MONTH_FEB)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_counter_unit.sv =====
// Gregorian date counter: top level with input register, date state and result register.
// An accepted word waits in the input register and moves to the result register when that slot is free.
// Throughput: one word per cycle unless the output stalls; the date update loop (leap check by
// one constant multiply, month length, rollover) is combinational.
// Reset (synchronous, active low): date 1 Jan 2000, both stages empty.
// Depends on gdc_pkg, gdc_step and gregorian_date_counter_unit_macros.svh.
module gregorian_date_counter_unit
    import gdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

`include "gregorian_date_counter_unit_macros.svh"

    // input register
    logic      r_in_valid;
    logic      n_in_valid;
    t_in_word  r_in;
    t_in_word  n_in;

    // stored date with the leap bit of its year
    t_date     r_date;
    t_date     n_date;

    // result register
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_word r_out;
    t_out_word n_out;

    t_date     step_date;
    t_out_word step_result;
    logic      in_take;
    logic      adv;
    logic      date_in_range;

    gdc_step u_step (
        .i_date   (r_date),
        .i_word   (r_in),
        .o_date   (step_date),
        .o_result (step_result)
    );

    // the held word moves on when the result slot is empty or being drained
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in        = r_in;
        n_date      = r_date;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (adv) begin
            n_in_valid  = 1'b0;
            n_date      = step_date;
            n_out_valid = 1'b1;
            n_out       = step_result;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (in_take) begin
            n_in_valid = 1'b1;
            n_in       = i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_date.day   <= DAY_FIRST;
            r_date.month <= MONTH_JAN;
            r_date.year  <= YEAR_RESET;
            r_date.leap  <= 1'b1;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_date      <= n_date;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign date_in_range = (r_date.year <= YEAR_MAX) && (r_date.month >= MONTH_JAN)
                           && (r_date.month <= MONTH_DEC) && (r_date.day >= DAY_FIRST);

    // leap bit tracks the stored year
    `GDC_ASSERT_ALWAYS(a_leap_track, r_date.leap == f_leap(r_date.year))
    // stored date stays in range
    `GDC_ASSERT_ALWAYS(a_date_range, date_in_range)
    // a compare word leaves the date alone
    `GDC_ASSERT_NEXT(a_cmp_keeps, adv && (r_in.action == ACT_CMP), r_date == $past(r_date))
    // every advanced word lands in the result register
    `GDC_ASSERT_NEXT(a_adv_out, adv, r_out_valid && (r_out.cur_year == r_date.year))

endmodule

// ===== hw/rtl/gdc_step.sv =====
// Next-date and result datapath of the date counter (combinational).
// Depends on gdc_pkg.
module gdc_step
    import gdc_pkg::*;
(
    input  t_date     i_date,
    input  t_in_word  i_word,
    output t_date     o_date,
    output t_out_word o_result
);

    t_year      ld_year;
    t_month     ld_month;
    logic       ld_leap;
    t_day       ld_len;
    t_day       ld_day;
    t_year      inc_year;
    logic       inc_leap;
    logic       month_end;
    logic       year_end;
    t_date      nx;
    t_days_left from_days;
    t_days_left left_days;
    logic       later;

    // load path, clamped to a valid date
    always_comb begin
        ld_year  = (i_word.load_year > YEAR_MAX) ? YEAR_MAX : i_word.load_year;
        if (i_word.load_month == 4'd0) begin
            ld_month = MONTH_JAN;
        end else if (i_word.load_month > MONTH_DEC) begin
            ld_month = MONTH_DEC;
        end else begin
            ld_month = i_word.load_month;
        end
        ld_leap = f_leap(ld_year);
        ld_len  = f_month_len(ld_month, ld_leap);
        if (i_word.load_day == 5'd0) begin
            ld_day = DAY_FIRST;
        end else if (i_word.load_day > ld_len) begin
            ld_day = ld_len;
        end else begin
            ld_day = i_word.load_day;
        end
    end

    // year rollover, leap of the following year in parallel
    assign inc_year  = (i_date.year >= YEAR_MAX) ? 14'd0 : (i_date.year + 14'd1);
    assign inc_leap  = f_leap(inc_year);
    assign month_end = (i_date.day >= f_month_len(i_date.month, i_date.leap));
    assign year_end  = (i_date.month >= MONTH_DEC);

    always_comb begin
        nx = i_date;
        case (i_word.action)
            ACT_LOAD: begin
                nx.day   = ld_day;
                nx.month = ld_month;
                nx.year  = ld_year;
                nx.leap  = ld_leap;
            end
            ACT_DAY: begin
                if (!month_end) begin
                    nx.day = i_date.day + 5'd1;
                end else begin
                    nx.day = DAY_FIRST;
                    if (year_end) begin
                        nx.month = MONTH_JAN;
                        nx.year  = inc_year;
                        nx.leap  = inc_leap;
                    end else begin
                        nx.month = i_date.month + 4'd1;
                    end
                end
            end
            ACT_MONTH: begin
                if (year_end) begin
                    nx.month = MONTH_JAN;
                    nx.year  = inc_year;
                    nx.leap  = inc_leap;
                end else begin
                    nx.month = i_date.month + 4'd1;
                end
            end
            default: begin
                nx = i_date;
            end
        endcase
    end

    // days left, floored at zero; a day past month end after a month step does not push it below zero
    assign from_days = f_days_from(nx.month, nx.leap);
    assign left_days = (from_days > {4'd0, nx.day}) ? (from_days - {4'd0, nx.day}) : 9'd0;

    // compare against the raw input date, year then month then day
    always_comb begin
        if (nx.year != i_word.load_year) begin
            later = (nx.year > i_word.load_year);
        end else if (nx.month != i_word.load_month) begin
            later = (nx.month > i_word.load_month);
        end else begin
            later = (nx.day > i_word.load_day);
        end
    end

    assign o_date             = nx;
    assign o_result.cur_day   = nx.day;
    assign o_result.cur_month = nx.month;
    assign o_result.cur_year  = nx.year;
    assign o_result.days_left = left_days;
    assign o_result.leap_flag = nx.leap;
    assign o_result.is_later  = later;

endmodule

// ===== dv/tb_gregorian_date_counter_unit.sv =====
// Self-checking testbench for gregorian_date_counter_unit: directed and random date words,
// an in-bench calendar predictor, random input gaps and random stalls on the output channel.
// Depends on gdc_pkg and the RTL of gregorian_date_counter_unit only.
module tb_gregorian_date_counter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gdc_pkg::*;

    // DUT ports; the inputs are driven to known values from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    gregorian_date_counter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Words waiting to be sent, and the results still owed by the DUT
    t_in_word  words_to_send[$];
    t_out_word dates_due[$];

    int  words_queued   = 0;  // written by the stimulus block only
    int  words_accepted = 0;  // written by the monitor only
    int  mismatches     = 0;
    bit  in_took        = 1'b0;
    bit  send_idle_en   = 1'b0;
    bit  recv_idle_en   = 1'b0;
    int  hold_requests  = 0;  // bumped by the stimulus block to ask for a long output hold

    // Predicted calendar state, kept at the DUT's widths
    t_day   cal_day   = DAY_FIRST;
    t_month cal_month = MONTH_JAN;
    t_year  cal_year  = YEAR_RESET;

    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(int m, int y);
        case (m)
            2:           return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Next month; December of the last year wraps to January of year 0
    function automatic void bump_month();
        if (cal_month == MONTH_DEC) begin
            cal_month = MONTH_JAN;
            cal_year  = (cal_year >= YEAR_MAX) ? t_year'(0) : t_year'(cal_year + 1);
        end else begin
            cal_month = t_month'(cal_month + 1);
        end
    endfunction

    // Applies one word to the predicted calendar and returns the result it should produce
    function automatic t_out_word advance_calendar(t_in_word w);
        t_out_word r;
        int gd, gm, gy;
        int d, m, y, len, left, mm;
        bit later;
        gd = w.load_day;
        gm = w.load_month;
        gy = w.load_year;
        case (w.action)
            ACT_LOAD: begin
                // out-of-range load fields saturate into a legal date
                y   = (gy > YEAR_MAX) ? YEAR_MAX : gy;
                m   = (gm == 0) ? 1 : ((gm > 12) ? 12 : gm);
                len = days_in_month(m, y);
                d   = (gd == 0) ? 1 : ((gd > len) ? len : gd);
                cal_day   = t_day'(d);
                cal_month = t_month'(m);
                cal_year  = t_year'(y);
            end
            ACT_DAY: begin
                // day may already overshoot after a month step, so compare in int
                if (int'(cal_day) + 1 > days_in_month(cal_month, cal_year)) begin
                    cal_day = DAY_FIRST;
                    bump_month();
                end else begin
                    cal_day = t_day'(cal_day + 1);
                end
            end
            ACT_MONTH: bump_month();
            default: ;
        endcase

        // the given date is compared as is, no clamping
        if (int'(cal_year) != gy) begin
            later = int'(cal_year) > gy;
        end else if (int'(cal_month) != gm) begin
            later = int'(cal_month) > gm;
        end else begin
            later = int'(cal_day) > gd;
        end

        left = days_in_month(cal_month, cal_year) - int'(cal_day);
        for (mm = int'(cal_month) + 1; mm <= 12; mm++) begin
            left += days_in_month(mm, cal_year);
        end
        if (left < 0) begin
            left = 0;
        end

        r.cur_day   = cal_day;
        r.cur_month = cal_month;
        r.cur_year  = cal_year;
        r.days_left = t_days_left'(left);
        r.leap_flag = is_leap(cal_year);
        r.is_later  = later;
        return r;
    endfunction

    // Mostly back-to-back, sometimes a few cycles, rarely a long gap
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Input driver: changes at the falling edge, holds a stalled word steady
    int in_gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_took) begin
            // word still waiting on the stall, keep it
        end else if (in_gap_left > 0) begin
            in_gap_left--;
            i_in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
            i_in_word   <= words_to_send.pop_front();
            i_in_valid  <= 1'b1;
            in_gap_left = send_idle_en ? idle_len() : 0;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output stall driver; a long hold is counted here, in cycles
    int out_gap_left = 0;
    int hold_left    = 0;
    int holds_seen   = 0;

    always @(negedge i_clk) begin
        if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (out_gap_left > 0) begin
            out_gap_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall  <= 1'b0;
            out_gap_left = recv_idle_en ? idle_len() : 0;
        end
    end

    // Monitor: checks each result against the oldest prediction, then predicts
    // for a word accepted at this edge (its result cannot show up at the same edge)
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            cal_day   = DAY_FIRST;
            cal_month = MONTH_JAN;
            cal_year  = YEAR_RESET;
            in_took   = 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (dates_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with nothing expected: %0d-%0d-%0d",
                                 $realtime, o_out_word.cur_year, o_out_word.cur_month,
                                 o_out_word.cur_day);
                    end
                end else begin
                    want = dates_due.pop_front();
                    if (o_out_word.cur_day   !== want.cur_day   ||
                        o_out_word.cur_month !== want.cur_month ||
                        o_out_word.cur_year  !== want.cur_year  ||
                        o_out_word.days_left !== want.days_left ||
                        o_out_word.leap_flag !== want.leap_flag ||
                        o_out_word.is_later  !== want.is_later) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: mismatch exp %0d-%0d-%0d left %0d leap %0b ",
                                      "later %0b, got %0d-%0d-%0d left %0d leap %0b later %0b"},
                                     $realtime, want.cur_year, want.cur_month, want.cur_day,
                                     want.days_left, want.leap_flag, want.is_later,
                                     o_out_word.cur_year, o_out_word.cur_month,
                                     o_out_word.cur_day, o_out_word.days_left,
                                     o_out_word.leap_flag, o_out_word.is_later);
                        end
                    end
                end
            end
            in_took = i_in_valid && !o_in_stall;
            if (in_took) begin
                dates_due.push_back(advance_calendar(i_in_word));
                words_accepted++;
            end
        end
    end

    task automatic push_word(t_action act, int d, int m, int y);
        t_in_word w;
        w.action     = act;
        w.load_day   = t_day'(d);
        w.load_month = t_month'(m);
        w.load_year  = t_year'(y);
        words_to_send.push_back(w);
        words_queued++;
    endtask

    // Same date, day or month off by at most one, or random day and month with the year off by at most one
    task automatic push_near(t_action act, int d, int m, int y);
        case ($urandom_range(0, 3))
            0:       push_word(act, d, m, y);
            1:       push_word(act, d + $urandom_range(0, 2) - 1, m, y);
            2:       push_word(act, d, m + $urandom_range(0, 2) - 1, y);
            default: push_word(act, $urandom, $urandom, y + $urandom_range(0, 2) - 1);
        endcase
    endtask

    function automatic int pick_year();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return YEAR_MAX;
            2:       return 100 * $urandom_range(0, 99);   // century years, some divisible by 400
            3:       return 4 * $urandom_range(0, 2499);
            4:       return $urandom_range(1895, 2105);
            default: return $urandom_range(0, 9999);
        endcase
    endfunction

    // Mostly a legal load, often near a month end, followed by steps, compares and loads;
    // the rest is raw noise over every bit of every field
    task automatic push_scenario();
        int y, m, d, len, n, r;
        if ($urandom_range(0, 9) >= 8) begin
            push_word(t_action'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end else begin
            y   = pick_year();
            m   = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
            len = days_in_month(m, y);
            d   = $urandom_range(0, 1) ? $urandom_range(len - 2, len) : $urandom_range(1, len);
            push_word(ACT_LOAD, d, m, y);
            n = $urandom_range(1, 12);
            repeat (n) begin
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    push_near(ACT_DAY, d, m, y);
                end else if (r < 7) begin
                    push_near(ACT_MONTH, d, m, y);
                end else if (r < 9) begin
                    push_near(ACT_CMP, d, m, y);
                end else begin
                    push_near(ACT_LOAD, d, m, y);
                end
            end
        end
    endtask

    task automatic fill(int count);
        int target;
        target = words_queued + count;
        while (words_queued < target) begin
            push_scenario();
        end
    endtask

    // Sender pause: return at a rising edge once every word is in and every result is out
    task automatic drain();
        while (words_accepted != words_queued || dates_due.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset date, year wrap by day and by month, load saturation,
        // leap rules, month overshoot, and compare on each field
        push_word(ACT_CMP,    1,  1,  2000);
        push_word(ACT_LOAD,  31, 12,  9999);
        push_word(ACT_DAY,   31, 12,  9999);
        push_word(ACT_LOAD,  31, 12,  9999);
        push_word(ACT_MONTH,  1,  1,     0);
        push_word(ACT_LOAD,   0,  0, 16383);
        push_word(ACT_LOAD,  31, 15, 10000);
        push_word(ACT_LOAD,  31, 13,  1900);
        push_word(ACT_LOAD,  31,  2,  2000);
        push_word(ACT_DAY,   29,  2,  2000);
        push_word(ACT_LOAD,  30,  2,  1900);
        push_word(ACT_DAY,    1,  3,  1900);
        push_word(ACT_LOAD,  28,  2,  2400);
        push_word(ACT_DAY,   28,  2,  2400);
        push_word(ACT_LOAD,  31,  1,  2023);
        push_word(ACT_MONTH, 31,  1,  2023);
        push_word(ACT_CMP,   31,  2,  2023);
        push_word(ACT_DAY,   31,  2,  2023);
        push_word(ACT_LOAD,  31,  4,  2021);
        push_word(ACT_CMP,   31, 15, 16383);
        push_word(ACT_CMP,    0,  0,     0);
        push_word(ACT_LOAD,  15,  6,  2024);
        push_word(ACT_CMP,   14,  6,  2024);
        push_word(ACT_CMP,   15,  7,  2024);
        push_word(ACT_CMP,   15,  6,  2023);
        drain();

        // Random, idling on both sides
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        fill(250);
        drain();

        // Long output hold while the sender keeps offering: the DUT must back up
        send_idle_en = 1'b0;
        hold_requests++;
        fill(250);
        drain();

        // Full rate, no idling anywhere
        recv_idle_en = 1'b0;
        fill(250);
        drain();

        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        fill(250);
        drain();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
